### src/rch_pkg.sv
`default_nettype none

package rch_pkg;

  localparam int DEF_QUANT_LEVELS = 16;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_CLR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic exec;        // finish a non-clear item
    logic clr_wr;      // zero one bin of the clear sweep
    logic clr_report;  // last sweep cycle of a requested clear
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

### src/rgb_color_histogram_core.sv
// Accumulate, read and the unused action: the transfer reads the bin store; EXEC then writes
//   an accumulate's bin and registers the strobe. busy stays high in EXEC, so a new item waits.
// Clear walks every bin (QUANT_LEVELS^3, 4096 by default), one per cycle, then strobes.
// Reset (rst_n low, synchronous) starts the same sweep, run with busy high and no strobe once
//   rst_n is high; cfg writes are taken whenever rst_n is high. The receiver cannot stall.
`default_nettype none

module rgb_color_histogram_core
  import rch_pkg::*;
#(
  // levels per color channel, 2..64; the bin store holds QUANT_LEVELS^3 counts
  parameter int QUANT_LEVELS = DEF_QUANT_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command side: a transfer happens when start is high and busy is low
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [23:0] in_pixel_rgb,
  input  wire logic [7:0]  in_mask_byte,
  input  wire logic [11:0] in_bin_select,
  // result side: one-cycle strobe, no backpressure
  output logic             out_valid,
  output logic [15:0]      out_bin_count,
  output logic [31:0]      out_pixel_total,
  // mask_enable register
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  cmd_t    cmd;
  status_t status;
  action_t action;

  assign action = action_t'(in_action);

  // Controller sequences idle / execute / clear sweep; the datapath owns the
  // bin store, the pixel total, the sweep counter and the result registers.
  rch_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rch_datapath #(
    .QUANT_LEVELS (QUANT_LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_action       (action),
    .in_pixel_rgb    (in_pixel_rgb),
    .in_mask_byte    (in_mask_byte),
    .in_bin_select   (in_bin_select),
    .out_valid       (out_valid),
    .out_bin_count   (out_bin_count),
    .out_pixel_total (out_pixel_total)
  );

endmodule

`default_nettype wire

### src/rch_ctrl.sv
`default_nettype none

module rch_ctrl
  import rch_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire action_t action,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = (action == ACT_CLEAR) ? ST_CLR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          cmd.clr_report = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_INIT_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/rch_datapath.sv
`default_nettype none

module rch_datapath
  import rch_pkg::*;
#(
  parameter int QUANT_LEVELS = DEF_QUANT_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire action_t     in_action,
  input  wire logic [23:0] in_pixel_rgb,
  input  wire logic [7:0]  in_mask_byte,
  input  wire logic [11:0] in_bin_select,
  output logic             out_valid,
  output logic [15:0]      out_bin_count,
  output logic [31:0]      out_pixel_total
);

  localparam int NUM_BINS = QUANT_LEVELS * QUANT_LEVELS * QUANT_LEVELS;
  localparam int AW       = $clog2(NUM_BINS);
  localparam int QW       = $clog2(QUANT_LEVELS);
  // floor(log2(256 / levels))
  localparam int QSHIFT   = $clog2(256 / QUANT_LEVELS + 1) - 1;
  localparam logic [7:0]    QMAX     = 8'(QUANT_LEVELS - 1);
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

  logic [15:0]   mem [NUM_BINS];

  logic          mask_en_r;
  logic [AW-1:0] clr_cnt_r;
  logic [31:0]   total_r;
  logic [15:0]   rd_data_r;
  action_t       act_r;
  logic          take_r;
  logic          oob_r;
  logic [AW-1:0] pix_addr_r;
  logic          out_valid_r;
  logic [15:0]   out_bin_count_r;
  logic [31:0]   out_pixel_total_r;

  logic [QW-1:0] q_r, q_g, q_b;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] rd_addr;
  logic          take;
  logic          oob;
  logic [15:0]   new_count;
  logic          upd_wr;

  function automatic logic [QW-1:0] quant(input logic [7:0] chan);
    logic [7:0] v;
    v = chan >> QSHIFT;
    if (v > QMAX) begin
      v = QMAX;
    end
    return QW'(v);
  endfunction

  always_comb begin
    q_r      = quant(in_pixel_rgb[7:0]);
    q_g      = quant(in_pixel_rgb[15:8]);
    q_b      = quant(in_pixel_rgb[23:16]);
    pix_addr = (AW'(q_r) * AW'(QUANT_LEVELS) + AW'(q_g)) * AW'(QUANT_LEVELS) + AW'(q_b);
    take     = !mask_en_r || (in_mask_byte != 8'h00);
    oob      = 32'(in_bin_select) >= 32'(NUM_BINS);
    rd_addr  = (in_action == ACT_READ) ? AW'(in_bin_select) : pix_addr;
  end

  assign new_count = (take_r && (rd_data_r != COUNT_MAX)) ? rd_data_r + 16'd1 : rd_data_r;
  assign upd_wr    = cmd.exec && (act_r == ACT_ACCUM) && take_r;
  assign status.clr_last = (clr_cnt_r == LAST_BIN);

  // bin store: one read port at transfer time, one write port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (upd_wr) begin
      mem[pix_addr_r] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r      <= in_action;
      take_r     <= take;
      oob_r      <= oob;
      pix_addr_r <= pix_addr;
    end
    if (cmd.exec) begin
      unique case (act_r)
        ACT_ACCUM: out_bin_count_r <= new_count;
        ACT_READ:  out_bin_count_r <= oob_r ? 16'd0 : rd_data_r;
        default:   out_bin_count_r <= 16'd0;
      endcase
      out_pixel_total_r <= upd_wr ? total_r + 32'd1 : total_r;
    end else if (cmd.clr_report) begin
      out_bin_count_r   <= 16'd0;
      out_pixel_total_r <= 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_en_r   <= 1'b0;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask_en_r <= cfg_wr_data;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= status.clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      if (cmd.accept && (in_action == ACT_CLEAR)) begin
        total_r <= '0;
      end else if (upd_wr) begin
        total_r <= total_r + 32'd1;
      end
      out_valid_r <= cmd.exec || cmd.clr_report;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_count   = out_bin_count_r;
  assign out_pixel_total = out_pixel_total_r;

endmodule

`default_nettype wire

### src/rch_checker.sv
`default_nettype none

module rch_checker
  import rch_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_action,
  input wire logic        out_valid
);

  // a transfer always makes the core busy next cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("core not busy after transfer");

  // a non-clear item strobes once the core has gone through EXEC
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action != ACT_CLEAR) |=> ##1 out_valid)
    else $error("missing result strobe");

  // a result comes when the core is back idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back strobes");

endmodule

bind rgb_color_histogram_core rch_checker u_rch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid)
);

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

// Testbench for rgb_color_histogram_core.
// The stimulus goes in through the start/busy command port. Each result is a one-cycle strobe.
// A behavioral histogram model runs next to the DUT. For each input transfer it
// queues the result it expects. Each strobe is compared with the oldest queued result.

module tb_top;
  import rch_pkg::*;

  // DUT runs with its default level count
  localparam int QL         = DEF_QUANT_LEVELS;
  localparam int NBINS      = QL * QL * QL;
  // floor(log2(256 / QL)): low bits dropped from each channel byte
  localparam int QSHIFT     = $clog2(256 / QL + 1) - 1;
  localparam logic [7:0] CHAN_LOW = 8'((1 << QSHIFT) - 1);
  localparam logic [23:0] LOW_BITS = {3{CHAN_LOW}};
  // longest legal quiet stretch is a full bin sweep (reset or clear) plus a sender gap
  localparam int WATCHDOG_LIMIT = 4 * NBINS + 2000;
  localparam int MAX_PRINTED    = 40;

  typedef struct {
    action_t     action;
    logic [23:0] rgb;
    logic [7:0]  mask_byte;
    logic [11:0] bin_select;
  } pixel_cmd_t;

  typedef struct {
    logic [15:0] bin_count;
    logic [31:0] pixel_total;
  } hist_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [23:0] in_pixel_rgb;
  logic [7:0]  in_mask_byte;
  logic [11:0] in_bin_select;
  logic        out_valid;
  logic [15:0] out_bin_count;
  logic [31:0] out_pixel_total;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  rgb_color_histogram_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_pixel_rgb   (in_pixel_rgb),
    .in_mask_byte   (in_mask_byte),
    .in_bin_select  (in_bin_select),
    .out_valid      (out_valid),
    .out_bin_count  (out_bin_count),
    .out_pixel_total(out_pixel_total),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Histogram model: bin store, running pixel total, mask mode register
  // ---------------------------------------------------------------------------
  logic [15:0]  bin_model [NBINS];
  logic [31:0]  total_model;
  logic         mask_model;
  hist_result_t expected_results[$];
  int           error_count;
  int           idle_cycles;

  // sender pacing: bursts of random length, gaps between them when gaps_on is set
  int           burst_left;
  bit           gaps_on;

  function automatic int quant_level(logic [7:0] chan);
    int v;
    v = int'(chan) >> QSHIFT;
    if (v > QL - 1) v = QL - 1;  // only hit when QL is not a power of two
    return v;
  endfunction

  // red is the most significant digit of the bin number
  function automatic int pixel_bin(logic [23:0] rgb);
    int idx;
    idx = (quant_level(rgb[7:0]) * QL + quant_level(rgb[15:8])) * QL
          + quant_level(rgb[23:16]);
    if (idx >= NBINS) idx = NBINS - 1;
    return idx;
  endfunction

  // Applies one command to the model and returns what the DUT should strobe out
  function automatic hist_result_t histogram_predict(pixel_cmd_t c);
    hist_result_t r;
    int idx;
    r.bin_count = '0;
    case (c.action)
      ACT_ACCUM: begin
        idx = pixel_bin(c.rgb);
        // masked-out pixel leaves everything alone but still reports its bin
        if (!mask_model || c.mask_byte != 8'h00) begin
          if (bin_model[idx] != COUNT_MAX) bin_model[idx] = bin_model[idx] + 16'd1;
          total_model = total_model + 32'd1;  // counts even when the bin is saturated
        end
        r.bin_count = bin_model[idx];
      end
      ACT_READ: begin
        r.bin_count = (int'(c.bin_select) < NBINS) ? bin_model[c.bin_select] : 16'd0;
      end
      ACT_CLEAR: begin
        foreach (bin_model[i]) bin_model[i] = '0;
        total_model = '0;
      end
      default: ;  // unused action: no state change, count 0
    endcase
    r.pixel_total = total_model;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    if (error_count < MAX_PRINTED)
      $display("mismatch @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, exp_v);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, input transfers, result checks, watchdog.
  // Everything is sampled at the rising edge before the NBA updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    hist_result_t exp_r;
    pixel_cmd_t   cmd;
    bit           moved;
    moved = 1'b0;
    if (cfg_wr_en === 1'b1) mask_model = cfg_wr_data;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, bin_count", 32'(out_bin_count), 32'd0);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_bin_count !== exp_r.bin_count)
          report_mismatch("bin_count", 32'(out_bin_count), 32'(exp_r.bin_count));
        if (out_pixel_total !== exp_r.pixel_total)
          report_mismatch("pixel_total", out_pixel_total, exp_r.pixel_total);
      end
    end
    // input transfer: start high while busy is low
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      moved          = 1'b1;
      cmd.action     = action_t'(in_action);
      cmd.rgb        = in_pixel_rgb;
      cmd.mask_byte  = in_mask_byte;
      cmd.bin_select = in_bin_select;
      expected_results.push_back(histogram_predict(cmd));
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Sends one command and returns at the edge of its transfer. Start is left high
  // so a back-to-back command keeps it high; gaps and drains lower it.
  task automatic send_cmd(action_t a, logic [23:0] rgb, logic [7:0] m, logic [11:0] sel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    in_action     <= a;
    in_pixel_rgb  <= rgb;
    in_mask_byte  <= m;
    in_bin_select <= sel;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Stop sending and hold off until every queued result has come back.
  // The first edge lets the monitor queue a transfer taken at the calling edge.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // mask_enable is only written once every queued result has come back
  task automatic write_mask(bit v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners of the pixel word, every action, clear in the middle of live data
  task automatic test_actions();
    write_mask(1'b0);
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'h000);          // empty store
    send_cmd(ACT_READ,  24'hFFFFFF, 8'hFF, 12'hFFF);
    send_cmd(ACT_ACCUM, 24'h000000, 8'h00, 12'hFFF);          // lowest bin
    send_cmd(ACT_ACCUM, 24'hFFFFFF, 8'hFF, 12'h000);          // highest bin
    send_cmd(ACT_ACCUM, LOW_BITS,   8'h55, 12'hAAA);          // dropped bits only -> bin 0
    send_cmd(ACT_ACCUM, ~LOW_BITS,  8'hAA, 12'h555);          // -> top bin
    send_cmd(ACT_ACCUM, 24'h0000FF, 8'h01, 12'h000);          // red alone
    send_cmd(ACT_ACCUM, 24'h00FF00, 8'h01, 12'h000);          // green alone
    send_cmd(ACT_ACCUM, 24'hFF0000, 8'h01, 12'h000);          // blue alone
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'd0);
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(NBINS - 1));
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(pixel_bin(24'h0000FF)));
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(pixel_bin(24'h00FF00)));
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(pixel_bin(24'hFF0000)));
    send_cmd(ACT_NONE,  24'hFFFFFF, 8'hFF, 12'hFFF);          // unused action
    send_cmd(ACT_CLEAR, 24'hFFFFFF, 8'hFF, 12'hFFF);
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'd0);
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(NBINS - 1));
    send_cmd(ACT_ACCUM, 24'h563412, 8'h00, 12'h000);
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(pixel_bin(24'h563412)));
  endtask

  // Mask mode: zero mask byte drops the pixel only while the mode is on
  task automatic test_mask();
    write_mask(1'b1);
    send_cmd(ACT_ACCUM, 24'h808080, 8'h00, 12'h000);          // masked out
    send_cmd(ACT_ACCUM, 24'h808080, 8'h01, 12'h000);
    send_cmd(ACT_ACCUM, 24'h808080, 8'h80, 12'h000);
    send_cmd(ACT_ACCUM, 24'h808080, 8'hFF, 12'h000);
    send_cmd(ACT_READ,  24'h000000, 8'h00, 12'(pixel_bin(24'h808080)));
    write_mask(1'b0);
    send_cmd(ACT_ACCUM, 24'h808080, 8'h00, 12'h000);          // counts again
  endtask

  // Pile pixels into one bin; only the dropped low bits vary, so the bin and the
  // total climb together, in bursts of back-to-back commands
  task automatic test_hot_bin();
    logic [23:0] base;
    base = 24'($urandom) & ~LOW_BITS;
    send_cmd(ACT_CLEAR, 24'h000000, 8'h00, 12'h000);
    repeat (180)
      send_cmd(ACT_ACCUM, base | (24'($urandom) & LOW_BITS), 8'($urandom), 12'($urandom));
    send_cmd(ACT_READ, 24'($urandom), 8'($urandom), 12'(pixel_bin(base)));
  endtask

  // Mixed traffic: mostly pixels, a few reads, a few unused actions, rare clears. Half the pixels come from
  // a small palette so bins build up counts that the reads can see.
  task automatic test_random_traffic();
    logic [23:0] palette [8];
    logic [23:0] rgb;
    logic [7:0]  m;
    logic [11:0] sel;
    int          pick;
    for (int phase = 0; phase < 4; phase++) begin
      write_mask(phase == 1 ? 1'b1 : phase == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
      foreach (palette[k]) palette[k] = 24'($urandom);
      for (int i = 0; i < 360; i++) begin
        if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if (phase == 2 && i == 200) drain_results();
        rgb  = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 7)] : 24'($urandom);
        m    = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        sel  = ($urandom_range(0, 9) < 6) ? 12'(pixel_bin(palette[$urandom_range(0, 7)]))
                                          : 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 1)       send_cmd(ACT_CLEAR, rgb, m, sel);
        else if (pick < 4)  send_cmd(ACT_NONE,  rgb, m, sel);
        else if (pick < 26) send_cmd(ACT_READ,  rgb, m, sel);
        else                send_cmd(ACT_ACCUM, rgb, m, sel);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (bin_model[i]) bin_model[i] = '0;
    total_model   = '0;
    mask_model    = 1'b0;
    error_count   = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_action     <= ACT_ACCUM;
    in_pixel_rgb  <= '0;
    in_mask_byte  <= '0;
    in_bin_select <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_actions();
    test_mask();
    test_hot_bin();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);  // catch any stray strobe
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/rch_pkg.sv
src/rch_ctrl.sv
src/rch_datapath.sv
src/rgb_color_histogram_core.sv
src/rch_checker.sv
sim/tb_top.sv
